// ===== src/hhtm_pkg.sv =====
// ----------------------------------------------------------------------------
// hhtm_pkg
// Shared constants, types and elaboration-time table builders for the
// half-float knee/gamma tone mapper.
// ----------------------------------------------------------------------------
package hhtm_pkg;

  // table geometry
  localparam int TIB    = 10;
  localparam int TAB_N  = 1 << TIB;
  localparam int LOG_W  = 17;
  localparam int EXP_W  = 18;
  localparam int LREM_W = 32 - TIB;
  localparam int EREM_W = 16 - TIB;

  // register stages from input transaction to output register
  localparam int PIPE_DEPTH = 12;

  // q16 curve constants
  localparam logic [18:0] MUL_Q16   = 19'd364089;
  localparam logic [13:0] KNEE_Q16  = 14'd12116;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [16:0] GAMMA_Q16 = 17'd29786;
  localparam logic [22:0] SCALE_Q16 = 23'd5548278;

  // ln2 / knee as a q24 reciprocal product
  localparam logic [25:0] KNEE_MUL = 26'((64'(LN2_Q16) << 24) / 64'(KNEE_Q16));

  typedef logic [63:0] u64_t;
  typedef u64_t roots_t [17];
  typedef logic [2*LOG_W-1:0] log_rom_t [TAB_N];
  typedef logic [2*EXP_W-1:0] exp_rom_t [TAB_N];

  typedef enum logic [1:0] {
    FRC_NONE = 2'b00,
    FRC_ZERO = 2'b01,
    FRC_SAT  = 2'b10
  } force_t;

  typedef struct packed {
    logic [5:0]  pos;
    logic [31:0] frac;
  } norm_t;

  // leading-one position and the 32 fraction bits below it
  function automatic norm_t norm35(input logic [34:0] v);
    logic [5:0]  pos;
    logic [34:0] sh;
    norm_t       res;
    pos = '0;
    for (int k = 0; k < 35; k++) begin
      if (v[k]) pos = 6'(k);
    end
    sh = v << (6'd34 - pos);
    res.pos  = pos;
    res.frac = sh[33:2];
    return res;
  endfunction

  // integer square root, elaboration only
  function automatic u64_t isqrt64(input u64_t n_in);
    u64_t n;
    u64_t res;
    u64_t bv;
    n   = n_in;
    res = '0;
    bv  = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // fractional log2 of a q30 mantissa by repeated squaring, q16 rounded
  function automatic u64_t exact_log2_frac(input u64_t z_in);
    u64_t z;
    u64_t r;
    z = z_in;
    r = '0;
    for (int i = 1; i <= 20; i++) begin
      z = (z * z) >> 30;
      if (z >= (64'd1 << 31)) begin
        z = z >> 1;
        r = r | (64'd1 << (20 - i));
      end
    end
    return (r + 64'd8) >> 4;
  endfunction

  function automatic roots_t calc_roots();
    roots_t rt;
    rt[0] = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) rt[j] = isqrt64(rt[j-1] << 30);
    return rt;
  endfunction

  function automatic u64_t log_val(input int i);
    if (i == TAB_N) return 64'd65536;
    return exact_log2_frac((64'd1 << 30) + (64'(i) << (30 - TIB)));
  endfunction

  function automatic u64_t exp_val(input int i, input roots_t rt);
    u64_t res;
    res = 64'd1 << 30;
    if (i == TAB_N) return 64'd131072;
    for (int j = 1; j <= TIB; j++) begin
      if (((i >> (TIB - j)) & 1) != 0) res = (res * rt[j]) >> 30;
    end
    return (res + (64'd1 << 13)) >> 14;
  endfunction

  // each word holds {entry i+1, entry i}
  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i < TAB_N; i++) begin
      rom[i] = {LOG_W'(log_val(i + 1)), LOG_W'(log_val(i))};
    end
    return rom;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    roots_t   rt;
    rt = calc_roots();
    for (int i = 0; i < TAB_N; i++) begin
      rom[i] = {EXP_W'(exp_val(i + 1, rt)), EXP_W'(exp_val(i, rt))};
    end
    return rom;
  endfunction

  // interpolated q16 log2 of a nonzero constant
  function automatic int log2_const(input u64_t val);
    int   p;
    u64_t frac;
    u64_t rem;
    u64_t lo;
    u64_t hi;
    int   idx;
    p = 63;
    while (val[p] == 1'b0) p--;
    if (p >= 32) frac = (val >> (p - 32)) & 64'hFFFF_FFFF;
    else         frac = (val << (32 - p)) & 64'hFFFF_FFFF;
    idx  = int'(frac >> LREM_W);
    rem  = frac & ((64'd1 << LREM_W) - 64'd1);
    lo   = log_val(idx);
    hi   = log_val(idx + 1);
    return (p - 16) * 65536 + int'(lo + (((hi - lo) * rem) >> LREM_W));
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam exp_rom_t EXP_ROM = build_exp_rom();
  localparam logic signed [24:0] LOG2_SCALE = 25'(log2_const(64'(SCALE_Q16)));

endpackage

// ===== src/hhtm_half_if.sv =====
// ----------------------------------------------------------------------------
// hhtm_half_if
// Stream channel carrying one pixel as four binary16 patterns.
// ----------------------------------------------------------------------------
interface hhtm_half_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_half;
  logic [15:0] green_half;
  logic [15:0] blue_half;
  logic [15:0] alpha_half;

  modport source (output valid, red_half, green_half, blue_half, alpha_half, input ready);
  modport sink   (input valid, red_half, green_half, blue_half, alpha_half, output ready);
endinterface

// ===== src/hhtm_byte_if.sv =====
// ----------------------------------------------------------------------------
// hhtm_byte_if
// Stream channel carrying one display pixel as four 8-bit intensities.
// ----------------------------------------------------------------------------
interface hhtm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_byte;
  logic [7:0] green_byte;
  logic [7:0] blue_byte;
  logic [7:0] alpha_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, alpha_byte, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, alpha_byte, output ready);
endinterface

// ===== src/hhtm_channel.sv =====
// ----------------------------------------------------------------------------
// hhtm_channel
// Twelve-stage datapath mapping one binary16 value to an 8-bit level:
// scale, log knee, gamma in the log2 domain, exp2, clamp.
// ----------------------------------------------------------------------------
module hhtm_channel (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] half_bits,
  output logic [7:0]  level
);
  import hhtm_pkg::*;

  localparam int LP_W = LOG_W + LREM_W;
  localparam int EP_W = EXP_W + EREM_W;

  // input decode and mantissa scaling
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [10:0] m_c;
  logic [4:0]  ex_c;
  force_t      frc_c;
  logic [29:0] prod_c;

  always_comb begin
    expo  = half_bits[14:10];
    mant  = half_bits[9:0];
    m_c   = (expo == 5'd0) ? {1'b0, mant} : {1'b1, mant};
    ex_c  = (expo == 5'd0) ? 5'd1 : expo;
    frc_c = FRC_NONE;
    if (half_bits[15]) begin
      frc_c = FRC_ZERO;
    end else if (expo == 5'd31) begin
      frc_c = (mant != 10'd0) ? FRC_ZERO : FRC_SAT;
    end else if (expo == 5'd0 && mant == 10'd0) begin
      frc_c = FRC_ZERO;
    end
    prod_c = 30'(m_c) * 30'(MUL_Q16);
  end

  logic [29:0] s1_prod;
  logic [4:0]  s1_ex;
  force_t      s1_frc;

  // align to q16
  logic [34:0] vfx_c;
  always_comb begin
    if (s1_ex >= 5'd25) vfx_c = 35'(s1_prod) << (s1_ex - 5'd25);
    else                vfx_c = 35'(s1_prod) >> (5'd25 - s1_ex);
  end

  logic [29:0] s2_prod;
  logic [4:0]  s2_ex;
  logic        s2_low;
  logic [34:0] s2_excess;
  force_t      s2_frc;

  // knee argument, or the linear value itself
  logic [48:0] wprod_c;
  logic [34:0] w_c;
  logic [34:0] x1_c;
  logic [5:0]  off_c;
  always_comb begin
    wprod_c = 49'(s2_excess) * 49'(KNEE_Q16);
    w_c     = 35'(wprod_c[48:16]) + 35'd65536;
    x1_c    = s2_low ? 35'(s2_prod) : w_c;
    off_c   = s2_low ? (6'(s2_ex) - 6'd25) : 6'd0;
  end

  logic [34:0] s3_x1;
  logic [5:0]  s3_off;
  logic        s3_low;
  force_t      s3_frc;

  // first log2: normalize and address the table
  norm_t      n1_c;
  logic [7:0] int1_c;
  always_comb begin
    n1_c   = norm35(s3_x1);
    int1_c = 8'(n1_c.pos) - 8'd16 + {{2{s3_off[5]}}, s3_off};
  end

  logic [2*LOG_W-1:0] s4_pair;
  logic [7:0]         s4_int;
  logic [LREM_W-1:0]  s4_rem;
  logic               s4_low;
  force_t             s4_frc;

  // first log2: interpolate
  logic [LOG_W-1:0] dif1_c;
  logic [LP_W-1:0]  ip1_c;
  logic [23:0]      lv1_c;
  always_comb begin
    dif1_c = s4_pair[2*LOG_W-1:LOG_W] - s4_pair[LOG_W-1:0];
    ip1_c  = LP_W'(dif1_c) * LP_W'(s4_rem);
    lv1_c  = {s4_int, 16'd0} + 24'(s4_pair[LOG_W-1:0]) + 24'(ip1_c >> LREM_W);
  end

  logic [23:0] s5_lv1;
  logic        s5_low;
  force_t      s5_frc;

  // ln2 / knee estimate by reciprocal product
  logic [47:0] kq_c;
  always_comb kq_c = 48'(s5_lv1[21:0]) * 48'(KNEE_MUL);

  logic [23:0] s6_lv1;
  logic [23:0] s6_q0;
  logic        s6_low;
  force_t      s6_frc;

  // quotient correction, estimate is low by at most one
  logic [38:0] t_c;
  logic [38:0] c_c;
  logic [23:0] knee_c;
  logic [24:0] x2_c;
  always_comb begin
    t_c    = 39'(s6_lv1[21:0]) * 39'(LN2_Q16);
    c_c    = (39'(s6_q0) + 39'd1) * 39'(KNEE_Q16);
    knee_c = (c_c <= t_c) ? s6_q0 + 24'd1 : s6_q0;
    x2_c   = 25'(knee_c) + 25'd65536;
  end

  logic [24:0] s7_x2;
  logic [23:0] s7_lv1;
  logic        s7_low;
  force_t      s7_frc;

  // second log2: normalize and address the table
  norm_t      n2_c;
  logic [7:0] int2_c;
  always_comb begin
    n2_c   = norm35(35'(s7_x2));
    int2_c = 8'(n2_c.pos) - 8'd16;
  end

  logic [2*LOG_W-1:0] s8_pair;
  logic [7:0]         s8_int;
  logic [LREM_W-1:0]  s8_rem;
  logic [23:0]        s8_lv1;
  logic               s8_low;
  force_t             s8_frc;

  // second log2: interpolate, pick the branch
  logic [LOG_W-1:0] dif2_c;
  logic [LP_W-1:0]  ip2_c;
  logic [23:0]      lv2_c;
  logic [23:0]      lv_c;
  always_comb begin
    dif2_c = s8_pair[2*LOG_W-1:LOG_W] - s8_pair[LOG_W-1:0];
    ip2_c  = LP_W'(dif2_c) * LP_W'(s8_rem);
    lv2_c  = {s8_int, 16'd0} + 24'(s8_pair[LOG_W-1:0]) + 24'(ip2_c >> LREM_W);
    lv_c   = s8_low ? s8_lv1 : lv2_c;
  end

  logic [23:0] s9_lv;
  force_t      s9_frc;

  // gamma product
  logic signed [39:0] lvg_c;
  always_comb lvg_c = $signed({{16{s9_lv[23]}}, s9_lv}) * $signed(40'(GAMMA_Q16));

  logic signed [39:0] s10_lvg;
  force_t             s10_frc;

  // q16 rescale rounding toward zero, add log2 of the output scale
  logic [39:0]      ysum_c;
  logic [24:0]      y_c;
  force_t           frc10_c;
  logic [TIB-1:0]   eidx_c;
  always_comb begin
    ysum_c  = s10_lvg + (s10_lvg[39] ? 40'd65535 : 40'd0);
    y_c     = {ysum_c[39], ysum_c[39:16]} + LOG2_SCALE;
    eidx_c  = y_c[15 -: TIB];
    frc10_c = s10_frc;
    if (s10_frc == FRC_NONE) begin
      if (y_c[24])                 frc10_c = FRC_ZERO;
      else if (y_c[23:19] != 5'd0) frc10_c = FRC_SAT;
    end
  end

  logic [2*EXP_W-1:0] s11_pair;
  logic [EREM_W-1:0]  s11_rem;
  logic [2:0]         s11_ip;
  force_t             s11_frc;

  // exp2 interpolate, shift, clamp
  logic [EXP_W-1:0] edif_c;
  logic [EP_W-1:0]  eip_c;
  logic [EXP_W-1:0] e_c;
  logic [EXP_W-1:0] r_c;
  logic [7:0]       byte_c;
  always_comb begin
    edif_c = s11_pair[2*EXP_W-1:EXP_W] - s11_pair[EXP_W-1:0];
    eip_c  = EP_W'(edif_c) * EP_W'(s11_rem);
    e_c    = s11_pair[EXP_W-1:0] + EXP_W'(eip_c >> EREM_W);
    r_c    = e_c >> (5'd16 - 5'(s11_ip));
    case (s11_frc)
      FRC_ZERO: byte_c = 8'd0;
      FRC_SAT:  byte_c = 8'd255;
      default:  byte_c = (r_c > EXP_W'(255)) ? 8'd255 : r_c[7:0];
    endcase
  end

  // pipeline registers, advance together
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod   <= prod_c;
      s1_ex     <= ex_c;
      s1_frc    <= frc_c;

      s2_prod   <= s1_prod;
      s2_ex     <= s1_ex;
      s2_low    <= (vfx_c <= 35'd65536);
      s2_excess <= vfx_c - 35'd65536;
      s2_frc    <= s1_frc;

      s3_x1     <= x1_c;
      s3_off    <= off_c;
      s3_low    <= s2_low;
      s3_frc    <= s2_frc;

      s4_pair   <= LOG_ROM[n1_c.frac[31 -: TIB]];
      s4_int    <= int1_c;
      s4_rem    <= n1_c.frac[LREM_W-1:0];
      s4_low    <= s3_low;
      s4_frc    <= s3_frc;

      s5_lv1    <= lv1_c;
      s5_low    <= s4_low;
      s5_frc    <= s4_frc;

      s6_lv1    <= s5_lv1;
      s6_q0     <= kq_c[47:24];
      s6_low    <= s5_low;
      s6_frc    <= s5_frc;

      s7_x2     <= x2_c;
      s7_lv1    <= s6_lv1;
      s7_low    <= s6_low;
      s7_frc    <= s6_frc;

      s8_pair   <= LOG_ROM[n2_c.frac[31 -: TIB]];
      s8_int    <= int2_c;
      s8_rem    <= n2_c.frac[LREM_W-1:0];
      s8_lv1    <= s7_lv1;
      s8_low    <= s7_low;
      s8_frc    <= s7_frc;

      s9_lv     <= lv_c;
      s9_frc    <= s8_frc;

      s10_lvg   <= lvg_c;
      s10_frc   <= s9_frc;

      s11_pair  <= EXP_ROM[eidx_c];
      s11_rem   <= y_c[EREM_W-1:0];
      s11_ip    <= y_c[18:16];
      s11_frc   <= frc10_c;

      level     <= byte_c;
    end
  end

endmodule

// ===== src/hdr_half_pixel_tone_map_core.sv =====
// Throughput: one pixel per cycle while the output is not stalled;
// all four channels run in parallel pipelines.
// The twelve register stages advance together and stall only while the output
// register holds a result that is not taken.
// Reset: synchronous active-high rst clears the stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// hdr_half_pixel_tone_map_core
// Top level: four channel pipelines sharing one valid chain and handshake.
// ----------------------------------------------------------------------------
module hdr_half_pixel_tone_map_core (
  input  logic clk,
  input  logic rst,
  hhtm_half_if.sink   pixel,
  hhtm_byte_if.source display
);
  import hhtm_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;

  // whole pipeline moves unless the output register is full and stalled
  assign en           = ~vld[PIPE_DEPTH-1] | display.ready;
  assign pixel.ready  = en;
  assign display.valid = vld[PIPE_DEPTH-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], pixel.valid};
    end
  end

  hhtm_channel u_red (
    .clk       (clk),
    .en        (en),
    .half_bits (pixel.red_half),
    .level     (display.red_byte)
  );

  hhtm_channel u_green (
    .clk       (clk),
    .en        (en),
    .half_bits (pixel.green_half),
    .level     (display.green_byte)
  );

  hhtm_channel u_blue (
    .clk       (clk),
    .en        (en),
    .half_bits (pixel.blue_half),
    .level     (display.blue_byte)
  );

  hhtm_channel u_alpha (
    .clk       (clk),
    .en        (en),
    .half_bits (pixel.alpha_half),
    .level     (display.alpha_byte)
  );

`ifndef SYNTHESIS
  // a stalled full output blocks new transactions
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    display.valid && !display.ready |-> !pixel.ready)
    else $error("input accepted while output stalled");

  // an accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> vld[0])
    else $error("accepted transaction lost at entry");

  // a stall keeps every stage's valid bit
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during stall");
`endif

endmodule
